/* rtl/bb3_pkg.sv */
// Shared types, constants and the reciprocal table of the 3x3 box blur.
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_W         = 24;
    localparam int CH_W          = 8;
    localparam int ROW_W         = 16;
    localparam int COL_OUT_W     = 10;
    localparam int CFG_WIDTH_W   = 11;
    localparam int CFG_HEIGHT_W  = 16;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int SUM_W         = 12;
    localparam int CNT_W         = 4;
    localparam int NUM_W         = 13;
    localparam int RECIP_W       = 17;
    localparam int RECIP_SHIFT   = 17;
    localparam int PROD_W        = NUM_W + RECIP_W;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic [CH_W-1:0]      out_red;
        logic [CH_W-1:0]      out_green;
        logic [CH_W-1:0]      out_blue;
        logic [ROW_W-1:0]     out_row;
        logic [COL_OUT_W-1:0] out_col;
        logic                 run_last;
        logic                 frame_done;
    } pixel_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CALC,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic calc;
        logic mult;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic any;
        logic last;
        logic out_free;
    } status_t;

    // ceil(2^17 / (2*count)); exact for numerators below 4600
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        unique case (cnt)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            4'd9:    m = 17'd7282;
            default: m = 17'd0;
        endcase
        return m;
    endfunction

endpackage

/* rtl/box_blur_3x3_rgb.sv */
// Top level of the 3x3 RGB box blur: configuration registers and block wiring.
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   in_pixel  (red, green, blue)
//  out       output     out_valid / out_stall out_pixel (means, row, col, flags)
//  config    input      APB psel/penable      image_width @0, image_height @4
//
// Each pixel is handled in steps: accept, then load, where the line store read lands and
// the window updates, then sum, divide and emit for each of the n = 0..4 results it
// releases, through the three per-channel reciprocal multipliers.
// Reset clears counters, window and state; the line stores are not cleared.
// in_stall is high whenever the sequencer is busy; out_stall holds a result
// in the output register and stops the sequencer only at its emit step.
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bb3_pkg::pixel_in_t            in_pixel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bb3_pkg::pixel_out_t           out_pixel,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bb3_pkg::PADDR_W-1:0]   paddr,
    input  logic [bb3_pkg::PDATA_W-1:0]   pwdata,
    output logic [bb3_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [bb3_pkg::CFG_WIDTH_W-1:0]  width_reg;
    logic [bb3_pkg::CFG_HEIGHT_W-1:0] height_reg;
    bb3_pkg::reg_idx_t                reg_sel;
    bb3_pkg::cmd_t                    cmd;
    bb3_pkg::status_t                 status;

    assign pready  = 1'b1;
    assign reg_sel = bb3_pkg::reg_idx_t'(paddr[2]);

    // take a write in the access phase of the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bb3_pkg::CFG_WIDTH_W'(bb3_pkg::WIDTH_RESET);
            height_reg <= bb3_pkg::CFG_HEIGHT_W'(bb3_pkg::HEIGHT_RESET);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                bb3_pkg::REG_WIDTH:  width_reg  <= pwdata[bb3_pkg::CFG_WIDTH_W-1:0];
                bb3_pkg::REG_HEIGHT: height_reg <= pwdata[bb3_pkg::CFG_HEIGHT_W-1:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            bb3_pkg::REG_WIDTH:  prdata = bb3_pkg::PDATA_W'(width_reg);
            bb3_pkg::REG_HEIGHT: prdata = bb3_pkg::PDATA_W'(height_reg);
            default:             prdata = '0;
        endcase
    end

    bb3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    bb3_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_pixel     (in_pixel),
        .image_width  (width_reg),
        .image_height (height_reg),
        .out_stall    (out_stall),
        .status       (status),
        .out_valid    (out_valid),
        .out_pixel    (out_pixel)
    );

endmodule

/* rtl/bb3_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bb3_ctrl.sv */
// Sequencer of the box blur: accept, load window, then sum, divide, emit per result.
module bb3_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bb3_pkg::status_t  status,
    output bb3_pkg::cmd_t     cmd,
    output logic              in_stall
);

    bb3_pkg::state_t state_reg;
    bb3_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bb3_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            bb3_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = bb3_pkg::ST_LOAD;
                end
            end
            bb3_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = status.any ? bb3_pkg::ST_CALC : bb3_pkg::ST_IDLE;
            end
            bb3_pkg::ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = bb3_pkg::ST_DIV;
            end
            bb3_pkg::ST_DIV:
            begin
                cmd.mult   = 1'b1;
                state_next = bb3_pkg::ST_EMIT;
            end
            bb3_pkg::ST_EMIT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.last ? bb3_pkg::ST_IDLE : bb3_pkg::ST_CALC;
                end
            end
            default:
            begin
                state_next = bb3_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == bb3_pkg::ST_LOAD)
        else $error("accepted transaction did not move to load");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result emitted into a busy output register");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.last) |=> (state_reg == bb3_pkg::ST_IDLE && !in_stall))
        else $error("last result did not release the input");
`endif

endmodule

/* rtl/bb3_dp.sv */
// Datapath of the box blur: line stores, window, counters, sums, divide, output register.
module bb3_dp #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bb3_pkg::cmd_t                     cmd,
    input  bb3_pkg::pixel_in_t                in_pixel,
    input  logic [bb3_pkg::CFG_WIDTH_W-1:0]   image_width,
    input  logic [bb3_pkg::CFG_HEIGHT_W-1:0]  image_height,
    input  logic                              out_stall,
    output bb3_pkg::status_t                  status,
    output logic                              out_valid,
    output bb3_pkg::pixel_out_t               out_pixel
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > bb3_pkg::CFG_WIDTH_W) ? CW + 1 : bb3_pkg::CFG_WIDTH_W;
    localparam int PW = bb3_pkg::PIX_W;
    localparam int RW = bb3_pkg::ROW_W;

    logic [PW-1:0] pix_reg;
    logic [PW-1:0] win_reg [3][3];
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] cur_row_reg;
    logic [CW-1:0] cur_col_reg;
    logic          hr1_reg;
    logic          hc0_reg;
    logic          hc1_reg;
    logic          ri_reg;
    logic          ci_reg;
    logic [bb3_pkg::SUM_W-1:0]  sum_reg [3];
    logic [bb3_pkg::CNT_W-1:0]  cnt_reg;
    logic [bb3_pkg::PROD_W-1:0] prod_reg [3];
    logic                       out_valid_reg;
    bb3_pkg::pixel_out_t        out_reg;

    logic [PW-1:0] older_rd;
    logic [PW-1:0] newer_rd;

    logic [EW-1:0] width_ext;
    logic [EW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic          last_col;
    logic          last_row;

    logic [2:0]                rmask;
    logic [2:0]                cmask;
    logic [bb3_pkg::SUM_W-1:0] sum_c [3];
    logic [bb3_pkg::CNT_W-1:0] cnt_c;
    logic                      adv_col;
    logic                      adv_row;

    bb3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (col_reg),
        .wdata (newer_rd),
        .re    (cmd.accept),
        .raddr (col_reg),
        .rdata (older_rd)
    );

    bb3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_newer (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (col_reg),
        .wdata (pix_reg),
        .re    (cmd.accept),
        .raddr (col_reg),
        .rdata (newer_rd)
    );

    // clamp the frame width to what the line stores hold; a zero width or height counts as one
    always_comb
    begin
        width_ext = EW'(image_width);
        priority if (width_ext == '0)
        begin
            w_eff = EW'(1);
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_ext;
        end
        h_eff    = (image_height == '0) ? RW'(1) : image_height;
        last_col = (EW'(col_reg) + EW'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + (RW + 1)'(1)) >= {1'b0, h_eff};
    end

    // window positions that fall inside the frame for the current result
    always_comb
    begin
        rmask[0] = !ri_reg && (cur_row_reg >= RW'(2));
        rmask[1] = cur_row_reg != '0;
        rmask[2] = 1'b1;
        cmask[0] = !ci_reg && (cur_col_reg >= CW'(2));
        cmask[1] = cur_col_reg != '0;
        cmask[2] = 1'b1;
        cnt_c    = '0;
        for (int k = 0; k < 3; k++)
        begin
            sum_c[k] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (rmask[i] && cmask[j])
                begin
                    cnt_c    = cnt_c + bb3_pkg::CNT_W'(1);
                    sum_c[0] = sum_c[0] + bb3_pkg::SUM_W'(win_reg[i][j][23:16]);
                    sum_c[1] = sum_c[1] + bb3_pkg::SUM_W'(win_reg[i][j][15:8]);
                    sum_c[2] = sum_c[2] + bb3_pkg::SUM_W'(win_reg[i][j][7:0]);
                end
            end
        end
    end

    assign adv_col = !ci_reg && hc1_reg;
    assign adv_row = !ri_reg && hr1_reg;

    assign status.any      = (row_reg != '0 || last_row) && (col_reg != '0 || last_col);
    assign status.last     = !adv_col && !adv_row;
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg <= in_pixel;
        end
        if (cmd.load)
        begin
            cur_row_reg <= row_reg;
            cur_col_reg <= col_reg;
        end
        if (cmd.calc)
        begin
            sum_reg <= sum_c;
            cnt_reg <= cnt_c;
        end
        if (cmd.mult)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= bb3_pkg::PROD_W'(
                                   {sum_reg[k], 1'b0} + bb3_pkg::NUM_W'(cnt_reg)) *
                               bb3_pkg::PROD_W'(bb3_pkg::recip(cnt_reg));
            end
        end
        if (cmd.emit)
        begin
            out_reg.out_red    <= prod_reg[0][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
            out_reg.out_green  <= prod_reg[1][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
            out_reg.out_blue   <= prod_reg[2][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
            out_reg.out_row    <= ri_reg ? cur_row_reg : cur_row_reg - RW'(1);
            out_reg.out_col    <= bb3_pkg::COL_OUT_W'(ci_reg ? cur_col_reg
                                                             : cur_col_reg - CW'(1));
            out_reg.run_last   <= status.last;
            out_reg.frame_done <= hr1_reg && hc1_reg && ri_reg && ci_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            hr1_reg       <= 1'b0;
            hc0_reg       <= 1'b0;
            hc1_reg       <= 1'b0;
            ri_reg        <= 1'b0;
            ci_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            if (cmd.load)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= older_rd;
                win_reg[1][2] <= newer_rd;
                win_reg[2][2] <= pix_reg;
                hr1_reg <= last_row;
                hc0_reg <= col_reg != '0;
                hc1_reg <= last_col;
                ri_reg  <= row_reg == '0;
                ci_reg  <= col_reg == '0;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (cmd.emit)
            begin
                // step to the next result in raster order
                priority if (adv_col)
                begin
                    ci_reg <= 1'b1;
                end
                else if (adv_row)
                begin
                    ri_reg <= 1'b1;
                    ci_reg <= !hc0_reg;
                end
                else
                begin
                    ri_reg <= ri_reg;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_reg;

endmodule

/* bench/blur_checker.sv */
// Predicts blurred pixels from observed input transactions and compares them with the output.
module blur_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  bb3_pkg::pixel_in_t           in_pixel,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  bb3_pkg::pixel_out_t          out_pixel,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bb3_pkg::PADDR_W-1:0]  paddr,
    input  logic [bb3_pkg::PDATA_W-1:0]  pwdata,
    output int                           fail_count,
    output int                           pending,
    output int                           seen_count
);

    localparam int MAXW = bb3_pkg::MAX_WIDTH_DEF;

    logic [bb3_pkg::CFG_WIDTH_W-1:0]  cur_width;
    logic [bb3_pkg::CFG_HEIGHT_W-1:0] cur_height;
    logic [bb3_pkg::PIX_W-1:0] line_old [MAXW];
    logic [bb3_pkg::PIX_W-1:0] line_new [MAXW];
    logic [bb3_pkg::PIX_W-1:0] win [3][3];
    int unsigned row_pos;
    int unsigned col_pos;
    bb3_pkg::pixel_out_t blurred_q [$];

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic bb3_pkg::pixel_out_t blur_at(int unsigned r, int unsigned c,
                                                     int unsigned orow, int unsigned ocol);
        int unsigned sr, sg, sb, cnt, wr, wc;
        longint y, x;
        bb3_pkg::pixel_out_t o;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            y = longint'(orow) + dr;
            if (y < 0 || y > longint'(r) || y < longint'(r) - 2) continue;
            wr = int'(y - (longint'(r) - 2));
            for (int dc = -1; dc <= 1; dc++)
            begin
                x = longint'(ocol) + dc;
                if (x < 0 || x > longint'(c) || x < longint'(c) - 2) continue;
                wc = int'(x - (longint'(c) - 2));
                sr += win[wr][wc][23:16];
                sg += win[wr][wc][15:8];
                sb += win[wr][wc][7:0];
                cnt++;
            end
        end
        o.out_red    = bb3_pkg::CH_W'((2 * sr + cnt) / (2 * cnt));
        o.out_green  = bb3_pkg::CH_W'((2 * sg + cnt) / (2 * cnt));
        o.out_blue   = bb3_pkg::CH_W'((2 * sb + cnt) / (2 * cnt));
        o.out_row    = bb3_pkg::ROW_W'(orow);
        o.out_col    = bb3_pkg::COL_OUT_W'(ocol);
        o.run_last   = 1'b0;
        o.frame_done = 1'b0;
        return o;
    endfunction

    task automatic predict_pixel(input bb3_pkg::pixel_in_t p);
        int unsigned w, h, r, c, idx, nr, nc, n;
        int unsigned rows [2];
        int unsigned cols [2];
        bit lc, lr;
        bb3_pkg::pixel_out_t o;
        w = (cur_width == 0) ? 1 : ((cur_width > MAXW) ? MAXW : cur_width);
        h = (cur_height == 0) ? 1 : cur_height;
        r = row_pos;
        c = col_pos;
        lc = (c + 1 >= w);
        lr = (r + 1 >= h);
        idx = (c < MAXW) ? c : MAXW - 1;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = line_old[idx];
        win[1][2] = line_new[idx];
        win[2][2] = p;
        line_old[idx] = line_new[idx];
        line_new[idx] = p;
        nr = 0; nc = 0; n = 0;
        if (r >= 1)
        begin
            rows[nr] = r - 1;
            nr = nr + 1;
        end
        if (lr)
        begin
            rows[nr] = r;
            nr = nr + 1;
        end
        if (c >= 1)
        begin
            cols[nc] = c - 1;
            nc = nc + 1;
        end
        if (lc)
        begin
            cols[nc] = c;
            nc = nc + 1;
        end
        for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++)
            begin
                o = blur_at(r, c, rows[i], cols[j]);
                o.frame_done = lr && lc && rows[i] == r && cols[j] == c;
                o.run_last = (i == nr - 1) && (j == nc - 1);
                blurred_q.push_back(o);
                n++;
            end
        if (lc)
        begin
            col_pos = 0;
            row_pos = lr ? 0 : ((r + 1) & 16'hFFFF);
        end
        else
            col_pos = c + 1;
    endtask

    task automatic check_result(input bb3_pkg::pixel_out_t got);
        bb3_pkg::pixel_out_t want;
        if (blurred_q.size() == 0)
        begin
            report($sformatf("unexpected result row %0d col %0d", got.out_row, got.out_col));
            return;
        end
        want = blurred_q.pop_front();
        if (got.out_red != want.out_red)
            report($sformatf("red %0d want %0d", got.out_red, want.out_red));
        if (got.out_green != want.out_green)
            report($sformatf("green %0d want %0d", got.out_green, want.out_green));
        if (got.out_blue != want.out_blue)
            report($sformatf("blue %0d want %0d", got.out_blue, want.out_blue));
        if (got.out_row != want.out_row)
            report($sformatf("row %0d want %0d", got.out_row, want.out_row));
        if (got.out_col != want.out_col)
            report($sformatf("col %0d want %0d", got.out_col, want.out_col));
        if (got.run_last != want.run_last)
            report($sformatf("run_last %0b want %0b", got.run_last, want.run_last));
        if (got.frame_done != want.frame_done)
            report($sformatf("frame_done %0b want %0b", got.frame_done, want.frame_done));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_width  = bb3_pkg::CFG_WIDTH_W'(bb3_pkg::WIDTH_RESET);
            cur_height = bb3_pkg::CFG_HEIGHT_W'(bb3_pkg::HEIGHT_RESET);
            row_pos = 0;
            col_pos = 0;
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                    win[a][b] = '0;
            for (int k = 0; k < MAXW; k++)
            begin
                line_old[k] = '0;
                line_new[k] = '0;
            end
            blurred_q.delete();
            fail_count = 0;
            seen_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == bb3_pkg::REG_WIDTH)
                    cur_width = pwdata[bb3_pkg::CFG_WIDTH_W-1:0];
                else
                    cur_height = pwdata[bb3_pkg::CFG_HEIGHT_W-1:0];
            end
            if (out_valid && !out_stall)
            begin
                check_result(out_pixel);
                seen_count++;
            end
            if (in_valid && !in_stall)
                predict_pixel(in_pixel);
        end
        pending = blurred_q.size();
    end

endmodule

/* bench/testbench.sv */
// Stimulus and verdict for the 3x3 RGB box blur, with the checker alongside.
module testbench;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    bb3_pkg::pixel_in_t in_pixel = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    bb3_pkg::pixel_out_t out_pixel;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [bb3_pkg::PADDR_W-1:0] paddr = '0;
    logic [bb3_pkg::PDATA_W-1:0] pwdata = '0;
    logic [bb3_pkg::PDATA_W-1:0] prdata;
    logic pready;

    int fail_count;
    int pending;
    int seen_count;
    int pixels_sent = 0;
    int frames_run = 0;
    // Receiver behavior: quiet means no random stalls, hold_req asks for one long stall.
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int hold_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    box_blur_3x3_rgb u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_pixel(in_pixel),
        .out_valid(out_valid), .out_stall(out_stall), .out_pixel(out_pixel),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    blur_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_pixel(in_pixel),
        .out_valid(out_valid), .out_stall(out_stall), .out_pixel(out_pixel),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .fail_count(fail_count), .pending(pending),
        .seen_count(seen_count)
    );

    // Receiver: stall at random about 12% of cycles, unless quiet or holding off.
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_cycles <= 60;
            out_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 12);
    end

    // Write one register: setup phase, then access phase; pready is always high.
    task automatic write_reg(input bb3_pkg::reg_idx_t idx,
                             input logic [bb3_pkg::PDATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= bb3_pkg::PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Send one pixel; hold it until the block takes it, then optionally idle.
    task automatic send_pixel(input bb3_pkg::pixel_in_t p, input bit may_idle);
        in_pixel <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
        @(negedge clk);
        if (may_idle && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    function automatic bb3_pkg::pixel_in_t rand_pixel();
        bb3_pkg::pixel_in_t p;
        p = bb3_pkg::pixel_in_t'(24'($urandom));
        return p;
    endfunction

    // Wait for every predicted result, then leave room for a result-free tail.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Run one whole frame of random pixels at the given size.
    task automatic run_frame(input int w, input int h, input bit may_idle);
        write_reg(bb3_pkg::REG_WIDTH, bb3_pkg::PDATA_W'(w));
        write_reg(bb3_pkg::REG_HEIGHT, bb3_pkg::PDATA_W'(h));
        @(negedge clk);
        for (int k = 0; k < w * h; k++)
            send_pixel(rand_pixel(), may_idle);
        drain();
        frames_run++;
    endtask

    initial
    begin
        bb3_pkg::pixel_in_t p;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed: extreme channel values on a 3x3 frame, then a single pixel.
        write_reg(bb3_pkg::REG_WIDTH, 32'd3);
        write_reg(bb3_pkg::REG_HEIGHT, 32'd3);
        for (int k = 0; k < 9; k++)
        begin
            p = (k % 2) ? bb3_pkg::pixel_in_t'(24'hFFFFFF) : bb3_pkg::pixel_in_t'(24'h000000);
            if (k == 4)
                p = bb3_pkg::pixel_in_t'(24'hAA55FF);
            send_pixel(p, 1'b0);
        end
        drain();
        frames_run++;
        // One-pixel frame: width and height zero count as one.
        write_reg(bb3_pkg::REG_WIDTH, 32'd0);
        write_reg(bb3_pkg::REG_HEIGHT, 32'd0);
        send_pixel(bb3_pkg::pixel_in_t'(24'h123456), 1'b0);
        drain();
        frames_run++;
        run_frame(1, 4, 1'b0);
        run_frame(5, 1, 1'b0);

        // Backpressure: hold off the receiver while the sender keeps offering pixels.
        write_reg(bb3_pkg::REG_WIDTH, 32'd4);
        write_reg(bb3_pkg::REG_HEIGHT, 32'd4);
        @(negedge clk);
        hold_req = 1'b1;
        for (int k = 0; k < 16; k++)
            send_pixel(rand_pixel(), 1'b0);
        drain();
        frames_run++;

        // Random frames, a quiet stretch among them.
        run_frame(6, 5, 1'b1);
        quiet = 1'b1;
        run_frame(7, 4, 1'b0);
        quiet = 1'b0;
        run_frame($urandom_range(2, 8), $urandom_range(2, 6), 1'b1);
        run_frame(16, 1, 1'b1);
        run_frame(2, 2, 1'b1);

        // Largest height register value: stream a few rows, then resize to end the frame.
        write_reg(bb3_pkg::REG_WIDTH, 32'd4);
        write_reg(bb3_pkg::REG_HEIGHT, 32'd65535);
        @(negedge clk);
        for (int k = 0; k < 12; k++)
            send_pixel(rand_pixel(), 1'b1);
        drain();
        write_reg(bb3_pkg::REG_HEIGHT, 32'd4);
        @(negedge clk);
        for (int k = 0; k < 4; k++)
            send_pixel(rand_pixel(), 1'b1);
        drain();
        frames_run++;

        run_frame(3, 3, 1'b1);

        $display("covered %0d frames, %0d pixels in, %0d results checked",
                 frames_run, pixels_sent, seen_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #400000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/bb3_pkg.sv
rtl/bb3_ram.sv
rtl/bb3_ctrl.sv
rtl/bb3_dp.sv
rtl/box_blur_3x3_rgb.sv
bench/blur_checker.sv
bench/testbench.sv
